FILE: rtl/core/lmgr_pkg.sv
// Package for the LED matrix glyph renderer: word types, font ROMs and palette.
`timescale 1ns / 1ps

package lmgr_pkg;

    // Panel geometry
    localparam int PANEL_ROWS_C   = 8;
    localparam int PANEL_COLS_C   = 32;
    localparam int GLYPH_HEIGHT_C = 8;

    // Font selection codes
    typedef enum logic [1:0] {
        FONT_DIGIT3 = 2'd0,
        FONT_ICON4  = 2'd1,
        FONT_ICON8  = 2'd2,
        FONT_NONE   = 2'd3
    } font_t;

    // Last column index per font
    localparam logic [2:0] LAST_COL_DIGIT3 = 3'd2;
    localparam logic [2:0] LAST_COL_ICON4  = 3'd3;
    localparam logic [2:0] LAST_COL_ICON8  = 3'd7;
    localparam logic [2:0] LAST_ROW        = 3'd7;

    // Color codes
    localparam logic [2:0] COLOR_BLACK = 3'd0;
    localparam logic [2:0] COLOR_ONE   = 3'd1;
    localparam logic [2:0] COLOR_TWO   = 3'd2;
    localparam logic [2:0] COLOR_THREE = 3'd3;
    localparam logic [2:0] COLOR_FOUR  = 3'd4;

    typedef struct packed {
        logic [1:0] req_type;
        logic [2:0] start_row;
        logic [4:0] start_col;
        logic [3:0] glyph;
        logic [2:0] color_code;
    } req_word_t;

    typedef struct packed {
        logic [7:0] led_index;
        logic       lit;
        logic [7:0] hue;
        logic [7:0] saturation;
        logic [7:0] brightness;
        logic       off_panel;
        logic       last;
    } pix_word_t;

    typedef struct packed {
        logic [7:0] hue;
        logic [7:0] saturation;
        logic [7:0] brightness;
    } hsv_t;

    // 3-column digit font, left column first
    function automatic logic [0:2][7:0] digit_cols(input logic [3:0] glyph);
        logic [0:2][7:0] cols;
        case (glyph)
            4'd0:    cols = {8'h7C, 8'h44, 8'h7C};
            4'd1:    cols = {8'h00, 8'h7C, 8'h00};
            4'd2:    cols = {8'h5C, 8'h54, 8'h74};
            4'd3:    cols = {8'h54, 8'h54, 8'h7C};
            4'd4:    cols = {8'h70, 8'h10, 8'h7C};
            4'd5:    cols = {8'h74, 8'h54, 8'h5C};
            4'd6:    cols = {8'h7C, 8'h54, 8'h5C};
            4'd7:    cols = {8'h40, 8'h40, 8'h7C};
            4'd8:    cols = {8'h7C, 8'h54, 8'h7C};
            4'd9:    cols = {8'h74, 8'h54, 8'h7C};
            default: cols = '0;
        endcase
        return cols;
    endfunction

    // 4-column icon font
    function automatic logic [0:3][7:0] icon4_cols(input logic [3:0] glyph);
        logic [0:3][7:0] cols;
        case (glyph)
            4'd0:    cols = {8'h5E, 8'h21, 8'h21, 8'h21};
            default: cols = '0;
        endcase
        return cols;
    endfunction

    // 8-column icon font
    function automatic logic [0:7][7:0] icon8_cols(input logic [3:0] glyph);
        logic [0:7][7:0] cols;
        case (glyph)
            4'd0: cols = {8'h00, 8'h00, 8'h3E, 8'h2A, 8'h2A, 8'h14, 8'h00, 8'h00};
            4'd1: cols = {8'h00, 8'h3E, 8'h41, 8'h41, 8'h41, 8'h6B, 8'h3E, 8'h00};
            4'd2: cols = {8'hFF, 8'hF1, 8'hF1, 8'hE1, 8'h81, 8'h81, 8'hE1, 8'hE1};
            4'd3: cols = {8'hF7, 8'hE0, 8'hC1, 8'h83, 8'hC1, 8'hE0, 8'hF7, 8'hFF};
            default: cols = '0;
        endcase
        return cols;
    endfunction

    // Column byte of a glyph; MSB is the top row
    function automatic logic [7:0] column_byte(input font_t font, input logic [3:0] glyph,
                                               input logic [2:0] col);
        logic [0:2][7:0] d;
        logic [0:3][7:0] i4;
        logic [0:7][7:0] i8;
        logic [7:0]      bits;
        d  = digit_cols(glyph);
        i4 = icon4_cols(glyph);
        i8 = icon8_cols(glyph);
        case (font)
            FONT_DIGIT3: bits = (col[1:0] == 2'd3) ? 8'h00 : d[col[1:0]];
            FONT_ICON4:  bits = i4[col[1:0]];
            FONT_ICON8:  bits = i8[col];
            default:     bits = 8'h00;
        endcase
        return bits;
    endfunction

    function automatic hsv_t palette(input logic [2:0] code);
        hsv_t c;
        case (code)
            COLOR_ONE:   c = '{hue: 8'd20,  saturation: 8'd240, brightness: 8'd240};
            COLOR_TWO:   c = '{hue: 8'd20,  saturation: 8'd160, brightness: 8'd240};
            COLOR_THREE: c = '{hue: 8'd120, saturation: 8'd120, brightness: 8'd240};
            COLOR_FOUR:  c = '{hue: 8'd180, saturation: 8'd120, brightness: 8'd240};
            default:     c = '0;
        endcase
        return c;
    endfunction

endpackage

FILE: rtl/core/led_matrix_glyph_renderer_core.sv
// Top level of the LED matrix glyph renderer: request walker and pixel output register.
`timescale 1ns / 1ps

//  channel | direction | handshake         | word
//  --------+-----------+-------------------+----------------------------------
//  request | in        | in_valid/in_stall | in_word  (font, origin, glyph, color)
//  pixel   | out       | out_valid/out_stall | out_word (index, color, flags)
//
//  One pixel word per cycle while out_stall is low: a glyph gives 24, 32 or 64
//  pixel words (8 rows times 3, 4 or 8 columns), set by the single column/row walker.
//  A new request is taken in the cycle its predecessor's last pixel is issued,
//  so glyphs stream back to back. A request with font code 3 gives no pixels.
//  Reset clears the walker and the output valid; no payload is reset.
//  out_stall holds a valid output word in the register and freezes the walker.

module led_matrix_glyph_renderer_core #(
    parameter int PANEL_COLS = lmgr_pkg::PANEL_COLS_C
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  lmgr_pkg::req_word_t in_word,
    output logic                out_valid,
    input  logic                out_stall,
    output lmgr_pkg::pix_word_t out_word
);

    import lmgr_pkg::*;

    // Request being walked
    logic       busy_reg, busy_next;
    req_word_t  req_reg, req_next;
    logic [2:0] col_reg, col_next;   // glyph column
    logic [2:0] row_reg, row_next;   // glyph row

    // Output register
    logic       out_valid_reg, out_valid_next;
    pix_word_t  out_reg, out_next;

    logic       advance;
    logic       accept;
    logic       last_pix;
    logic [2:0] last_col;
    logic [7:0] bits;
    logic       set_bit;
    logic [2:0] inv_code;
    logic [2:0] eff_code;
    logic [3:0] pan_row;
    logic [5:0] pan_col;
    logic       off;
    hsv_t       hsv;

    // Walker advances when the output register is free or draining
    assign advance = busy_reg && (!out_valid_reg || !out_stall);

    always_comb
    begin
        case (font_t'(req_reg.req_type))
            FONT_DIGIT3: last_col = LAST_COL_DIGIT3;
            FONT_ICON4:  last_col = LAST_COL_ICON4;
            default:     last_col = LAST_COL_ICON8;
        endcase
    end

    assign last_pix = (col_reg == last_col) && (row_reg == LAST_ROW);
    assign in_stall = busy_reg && !(advance && last_pix);
    assign accept   = in_valid && !in_stall;

    // Pixel datapath
    always_comb
    begin
        bits     = column_byte(font_t'(req_reg.req_type), req_reg.glyph, col_reg);
        set_bit  = bits[3'd7 - row_reg];
        inv_code = (req_reg.color_code == COLOR_BLACK) ? COLOR_ONE : COLOR_BLACK;
        eff_code = set_bit ? req_reg.color_code : inv_code;
        pan_row  = {1'b0, req_reg.start_row} + {1'b0, row_reg};
        pan_col  = {1'b0, req_reg.start_col} + {3'b000, col_reg};
        off      = (pan_row >= 4'(PANEL_ROWS_C)) || (pan_col >= 6'(PANEL_COLS));
        hsv      = palette(eff_code);

        out_next = out_reg;
        if (advance)
        begin
            if (off)
            begin
                out_next           = '0;
                out_next.off_panel = 1'b1;
            end
            else
            begin
                // serpentine: odd columns run bottom to top
                out_next.led_index  = pan_col[0] ? {pan_col[4:0], ~pan_row[2:0]}
                                                 : {pan_col[4:0], pan_row[2:0]};
                out_next.lit        = (eff_code >= COLOR_ONE) && (eff_code <= COLOR_FOUR);
                out_next.hue        = hsv.hue;
                out_next.saturation = hsv.saturation;
                out_next.brightness = hsv.brightness;
                out_next.off_panel  = 1'b0;
            end
            out_next.last = last_pix;
        end
    end

    // Walker control
    always_comb
    begin
        busy_next      = busy_reg;
        req_next       = req_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        out_valid_next = advance ? 1'b1 : (out_valid_reg && out_stall);

        if (advance)
        begin
            if (last_pix)
                busy_next = 1'b0;
            else if (row_reg == LAST_ROW)
            begin
                row_next = '0;
                col_next = col_reg + 3'd1;
            end
            else
                row_next = row_reg + 3'd1;
        end

        if (accept)
        begin
            req_next  = in_word;
            busy_next = (font_t'(in_word.req_type) != FONT_NONE);
            col_next  = '0;
            row_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            col_reg       <= '0;
            row_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
        out_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_reg;

endmodule

FILE: tb/sv/tb_led_matrix_glyph_renderer_core.sv
// Self-checking testbench for the LED matrix glyph renderer core.
`timescale 1ns / 1ps

module tb_led_matrix_glyph_renderer_core;

    import lmgr_pkg::*;

    // The watchdog allows several times the longest legal run, in which every
    // pixel word waits out a long stall.
    localparam int unsigned CYCLE_LIMIT  = 2_000_000;
    localparam int          DRAIN_CYCLES = 80;    // one full 8-column glyph plus margin
    localparam int          HOLD_CYCLES  = 400;   // receiver hold-off in the pressure test
    localparam int          RANDOM_WORDS = 150;
    localparam int          MAX_REPORTS  = 40;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_stall;
    req_word_t in_word   = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    pix_word_t out_word;

    // Pixel words predicted for accepted requests, oldest first.
    pix_word_t   pixel_queue[$];
    int unsigned err_count   = 0;
    int unsigned cycle_count = 0;

    // Idle controls: sender gaps, receiver stalls, and the pressure hold-off
    // handshake (a request count the receiver catches up with).
    bit gaps_on  = 1'b1;
    bit stall_on = 1'b1;
    int hold_off_requests = 0;

    led_matrix_glyph_renderer_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word)
    );

    initial
    begin : clock_gen
        forever #4 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Whole glyph as 64 bits: column c is byte c counted from the top end,
    // and within a byte the MSB is the top row. Unused columns stay zero.
    function automatic logic [63:0] glyph_columns(input font_t font, input logic [3:0] glyph);
        logic [63:0] cols;
        cols = '0;
        case (font)
            FONT_DIGIT3:
            begin
                case (glyph)
                    4'd0:    cols[63:40] = 24'h7C447C;
                    4'd1:    cols[63:40] = 24'h007C00;
                    4'd2:    cols[63:40] = 24'h5C5474;
                    4'd3:    cols[63:40] = 24'h54547C;
                    4'd4:    cols[63:40] = 24'h70107C;
                    4'd5:    cols[63:40] = 24'h74545C;
                    4'd6:    cols[63:40] = 24'h7C545C;
                    4'd7:    cols[63:40] = 24'h40407C;
                    4'd8:    cols[63:40] = 24'h7C547C;
                    4'd9:    cols[63:40] = 24'h74547C;
                    default: cols = '0;
                endcase
            end
            FONT_ICON4:
            begin
                if (glyph == 4'd0)
                    cols[63:32] = 32'h5E212121;
            end
            FONT_ICON8:
            begin
                case (glyph)
                    4'd0:    cols = 64'h00003E2A2A140000;
                    4'd1:    cols = 64'h003E4141416B3E00;
                    4'd2:    cols = 64'hFFF1F1E18181E1E1;
                    4'd3:    cols = 64'hF7E0C183C1E0F7FF;
                    default: cols = '0;
                endcase
            end
            default: cols = '0;
        endcase
        return cols;
    endfunction

    function automatic hsv_t shade(input logic [2:0] code);
        hsv_t c;
        case (code)
            COLOR_ONE:   c = '{hue: 8'd20,  saturation: 8'd240, brightness: 8'd240};
            COLOR_TWO:   c = '{hue: 8'd20,  saturation: 8'd160, brightness: 8'd240};
            COLOR_THREE: c = '{hue: 8'd120, saturation: 8'd120, brightness: 8'd240};
            COLOR_FOUR:  c = '{hue: 8'd180, saturation: 8'd120, brightness: 8'd240};
            default:     c = '0;   // black, codes 5..7 included
        endcase
        return c;
    endfunction

    // Queue every pixel word one request gives, column by column, top row first.
    function automatic void render_glyph(input req_word_t req);
        logic [63:0] cols;
        logic [2:0]  eff;
        int          ncols;
        int          row;
        int          col;
        int          idx;
        pix_word_t   px;
        hsv_t        hsv;
        case (font_t'(req.req_type))
            FONT_DIGIT3: ncols = 3;
            FONT_ICON4:  ncols = 4;
            FONT_ICON8:  ncols = 8;
            default:     return;   // no font selected: no pixels
        endcase
        cols = glyph_columns(font_t'(req.req_type), req.glyph);
        for (int c = 0; c < ncols; c++)
        begin
            for (int r = 0; r < GLYPH_HEIGHT_C; r++)
            begin
                row = int'(req.start_row) + r;
                col = int'(req.start_col) + c;
                // clear bits take the inverse code: code 1 under a black
                // foreground, black otherwise
                if (cols[63 - 8 * c - r])
                    eff = req.color_code;
                else if (req.color_code == COLOR_BLACK)
                    eff = COLOR_ONE;
                else
                    eff = COLOR_BLACK;
                px = '0;
                if (row >= PANEL_ROWS_C || col >= PANEL_COLS_C)
                begin
                    px.off_panel = 1'b1;
                end
                else
                begin
                    // serpentine chain: odd columns run bottom to top
                    idx = col[0] ? col * 8 + 7 - row : col * 8 + row;
                    hsv = shade(eff);
                    px.led_index  = idx[7:0];
                    px.lit        = (eff >= COLOR_ONE && eff <= COLOR_FOUR);
                    px.hue        = hsv.hue;
                    px.saturation = hsv.saturation;
                    px.brightness = hsv.brightness;
                end
                px.last = (c == ncols - 1) && (r == GLYPH_HEIGHT_C - 1);
                pixel_queue.push_back(px);
            end
        end
    endfunction

    // ------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------

    // Mostly back to back, some short gaps, a few long ones.
    function automatic int idle_cycles();
        int pick;
        if (!gaps_on)
            return 0;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            return 0;
        if (pick < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic req_word_t mk_req(input font_t font, input int row, input int col,
                                         input int glyph, input int color);
        req_word_t r;
        r.req_type   = font;
        r.start_row  = 3'(row);
        r.start_col  = 5'(col);
        r.glyph      = 4'(glyph);
        r.color_code = 3'(color);
        return r;
    endfunction

    // Offer one request word and hold it until accepted. in_valid stays high
    // afterwards so a following word can go out with no gap; it is lowered
    // only at the start of a gap, so each step sees one assignment at most.
    task automatic send_request(input req_word_t req);
        int gap;
        gap = idle_cycles();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= req;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        render_glyph(req);
    endtask

    // ------------------------------------------------------------------
    // Receiver: random stalls, plus a long hold-off on request
    // ------------------------------------------------------------------

    initial
    begin : receiver
        int  served;
        int  n;
        logic v;
        served = 0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (served != hold_off_requests)
            begin
                served = hold_off_requests;
                v = 1'b1;
                n = HOLD_CYCLES;
            end
            else if (stall_on && $urandom_range(0, 2) == 0)
            begin
                v = 1'b1;
                n = 1 + idle_cycles();
            end
            else
            begin
                v = 1'b0;
                n = $urandom_range(1, 6);
            end
            out_stall <= v;
            repeat (n) @(posedge clk);
        end
    end

    // ------------------------------------------------------------------
    // Checker
    // ------------------------------------------------------------------

    function automatic void compare_field(input string name, input int unsigned want,
                                          input int unsigned got);
        if (want != got)
        begin
            err_count++;
            if (err_count <= MAX_REPORTS)
                $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
        end
    endfunction

    always @(posedge clk)
    begin : pixel_checker
        pix_word_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pixel_queue.size() == 0)
            begin
                err_count++;
                if (err_count <= MAX_REPORTS)
                    $display("%0t: unexpected pixel word, expected none actual %h",
                             $time, out_word);
            end
            else
            begin
                want = pixel_queue.pop_front();
                compare_field("led_index",  want.led_index,  out_word.led_index);
                compare_field("lit",        want.lit,        out_word.lit);
                compare_field("hue",        want.hue,        out_word.hue);
                compare_field("saturation", want.saturation, out_word.saturation);
                compare_field("brightness", want.brightness, out_word.brightness);
                compare_field("off_panel",  want.off_panel,  out_word.off_panel);
                compare_field("last",       want.last,       out_word.last);
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Field extremes, panel corners and edges, every font code.
    task automatic test_extremes();
        send_request(mk_req(FONT_DIGIT3, 0, 0, 0, 1));
        send_request(mk_req(FONT_ICON8, 7, 31, 15, 7));   // almost all off panel
        send_request(mk_req(FONT_ICON4, 0, 0, 0, 0));     // black foreground
        send_request(mk_req(FONT_ICON8, 0, 24, 2, 4));    // fills the right edge exactly
        send_request(mk_req(FONT_ICON8, 0, 25, 3, 3));    // last column falls off
        send_request(mk_req(FONT_DIGIT3, 4, 30, 8, 2));   // off right and bottom
        send_request(mk_req(FONT_NONE, 0, 0, 0, 1));      // no pixels
        send_request(mk_req(FONT_NONE, 7, 31, 15, 7));
        send_request(mk_req(FONT_ICON8, 1, 10, 1, 3));
    endtask

    // Every color code on one digit, codes 5..7 draw black.
    task automatic test_color_codes();
        for (int code = 0; code < 8; code++)
            send_request(mk_req(FONT_DIGIT3, 0, 2 * code + 1, 8, code));
        send_request(mk_req(FONT_ICON8, 0, 16, 0, 4));
    endtask

    // Glyph numbers with no ROM content read as blank columns.
    task automatic test_undefined_glyphs();
        send_request(mk_req(FONT_DIGIT3, 0, 5, 10, 3));
        send_request(mk_req(FONT_DIGIT3, 2, 6, 15, 0));
        send_request(mk_req(FONT_ICON4, 0, 7, 1, 2));
        send_request(mk_req(FONT_ICON8, 0, 8, 4, 1));
    endtask

    function automatic req_word_t random_request();
        req_word_t r;
        int        pick;
        pick = $urandom_range(0, 99);
        if (pick < 8)
            r.req_type = FONT_NONE;
        else
            r.req_type = 2'($urandom_range(0, 2));
        // about half the glyphs start at the top row so whole glyphs land
        r.start_row = ($urandom_range(0, 1) == 0) ? 3'd0 : 3'($urandom_range(0, 7));
        r.start_col = 5'($urandom_range(0, 31));
        if ($urandom_range(0, 99) < 15)
            r.glyph = 4'($urandom_range(0, 15));
        else if (r.req_type == FONT_DIGIT3)
            r.glyph = 4'($urandom_range(0, 9));
        else if (r.req_type == FONT_ICON8)
            r.glyph = 4'($urandom_range(0, 3));
        else
            r.glyph = 4'd0;
        if ($urandom_range(0, 99) < 80)
            r.color_code = 3'($urandom_range(0, 4));
        else
            r.color_code = 3'($urandom_range(0, 7));
        return r;
    endfunction

    // Random glyphs; the middle stretch runs with no gaps and no stalls.
    task automatic test_random_stream();
        for (int i = 0; i < RANDOM_WORDS; i++)
        begin
            gaps_on  = !(i >= 60 && i < 90);
            stall_on = gaps_on;
            send_request(random_request());
        end
        gaps_on  = 1'b1;
        stall_on = 1'b1;
    endtask

    // Receiver holds off for a long stretch while requests keep coming, so the
    // core fills up and stalls its request side.
    task automatic test_backpressure();
        gaps_on = 1'b0;
        hold_off_requests++;
        for (int i = 0; i < 8; i++)
            send_request(mk_req(FONT_ICON8, 0, 4 * i, i % 4, 1 + i % 4));
        gaps_on = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Sequencer and watchdog
    // ------------------------------------------------------------------

    initial
    begin : sequencer
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_extremes();
        test_color_codes();
        test_undefined_glyphs();
        test_random_stream();
        test_backpressure();
        in_valid <= 1'b0;
        while (pixel_queue.size() != 0)
            @(posedge clk);
        // a trailing request may still be in flight without any pixel word
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_count == 0)
            $display("led_matrix_glyph_renderer_core: match");
        else
            $display("led_matrix_glyph_renderer_core: mismatch");
        $finish;
    end

    initial
    begin : watchdog
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT)
            begin
                $display("%0t: timeout, %0d pixel words outstanding", $time,
                         pixel_queue.size());
                $display("led_matrix_glyph_renderer_core: mismatch");
                $finish;
            end
        end
    end

endmodule
